[rtl/core/coordinate_hashed_lcg_random_unit_macros.svh]
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef COORDINATE_HASHED_LCG_RANDOM_UNIT_MACROS_SVH
`define COORDINATE_HASHED_LCG_RANDOM_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CHL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHL_ASSERT(lbl, cond, msg)
`define CHL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/chlcg_pkg.sv]
package chlcg_pkg;

  localparam int unsigned SEED_W = 48;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned OUT_W = 64;
  localparam int unsigned CMD_W = 3;

  localparam logic [SEED_W-1:0] LCG_MUL = 48'h0005_DEEC_E66D;
  localparam logic [SEED_W-1:0] LCG_ADD = 48'd11;
  localparam logic [15:0] X_WEIGHT = 16'd49632;
  localparam logic [18:0] Y_WEIGHT = 19'd325176;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE   = 3'd0,
    CMD_SHORT  = 3'd1,
    CMD_INT    = 3'd2,
    CMD_LONG   = 3'd3,
    CMD_FLOAT  = 3'd4,
    CMD_DOUBLE = 3'd5
  } cmd_t;

endpackage

[rtl/core/coordinate_hashed_lcg_random_unit.sv]
// Coordinate noise generator: each transaction carries a grid point and a
// format code and returns one word of random bits derived from the seed
// register and the point, with no state kept between transactions. One
// transaction is taken every clock while in_ready is high; out_valid comes from
// the last of seven register stages (the input stage included). The pipeline
// is set by the two 48-bit LCG
// steps, each split into a partial-product stage and a summing stage, plus
// the coordinate multiply, seed-mix and output-format stages. Each stage
// stalls only when it holds data that the next stage cannot take, so
// bubbles are squeezed out under backpressure. Write cfg_wdata only while
// no transaction is in flight.
`include "coordinate_hashed_lcg_random_unit_macros.svh"

module coordinate_hashed_lcg_random_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chlcg_pkg::SEED_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [chlcg_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [chlcg_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [chlcg_pkg::COORD_W-1:0] in_coord_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [chlcg_pkg::OUT_W-1:0]         out_random_bits
);
  import chlcg_pkg::*;

  logic [SEED_W-1:0] seed_r;

  // stage registers
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic [CMD_W-1:0]  cmd1_r, cmd2_r, cmd3_r, cmd4_r, cmd5_r, cmd6_r, out_cmd_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic [SEED_W-1:0] s_r, pl0_r, s0_r, s0b_r, pl1_r, s0c_r, s1_r;
  logic [23:0]       ph0_r, ph1_r;
  logic [OUT_W-1:0]  out_random_bits_r;

  logic [COORD_W-1:0] px_nxt, py_nxt, off32;
  logic [SEED_W-1:0] s_nxt, pl0_nxt, s0_nxt, pl1_nxt, s1_nxt;
  logic [23:0]       ph0_nxt, ph1_nxt;
  logic [OUT_W-1:0]  out_random_bits_nxt;

  logic en1, en2, en3, en4, en5, en6, en_o;

  // a stage moves when it is empty or the stage after it moves
  assign en_o = !out_valid_r || out_ready;
  assign en6  = !v6_r || en_o;
  assign en5  = !v5_r || en6;
  assign en4  = !v4_r || en5;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    px_nxt  = 32'($unsigned(in_coord_x) * X_WEIGHT);
    py_nxt  = 32'($unsigned(in_coord_y) * Y_WEIGHT);
    off32   = px_r + py_r;
    s_nxt   = (seed_r + {{(SEED_W-COORD_W){off32[COORD_W-1]}}, off32}) ^ LCG_MUL;
    // s*MUL mod 2^48 = lo*MUL + (hi*MUL[23:0] << 24)
    pl0_nxt = 48'({24'd0, s_r[23:0]} * LCG_MUL);
    ph0_nxt = 24'(s_r[47:24] * LCG_MUL[23:0]);
    s0_nxt  = pl0_r + {ph0_r, 24'd0} + LCG_ADD;
    pl1_nxt = 48'({24'd0, s0_r[23:0]} * LCG_MUL);
    ph1_nxt = 24'(s0_r[47:24] * LCG_MUL[23:0]);
    s1_nxt  = pl1_r + {ph1_r, 24'd0} + LCG_ADD;
    case (cmd_t'(cmd6_r))
      CMD_BYTE:   out_random_bits_nxt = {56'd0, s0c_r[47:40]};
      CMD_SHORT:  out_random_bits_nxt = {48'd0, s0c_r[47:32]};
      CMD_INT:    out_random_bits_nxt = {32'd0, s0c_r[47:16]};
      CMD_LONG:   out_random_bits_nxt = {s0c_r[47:16], s1_r[47:16]};
      CMD_FLOAT:  out_random_bits_nxt = {40'd0, s0c_r[47:24]};
      // the 26 high bits shifted by 27 and the 27 low bits do not overlap
      CMD_DOUBLE: out_random_bits_nxt = {11'd0, s0c_r[47:22], s1_r[47:21]};
      default:    out_random_bits_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (en1)  v1_r        <= in_valid;
      if (en2)  v2_r        <= v1_r;
      if (en3)  v3_r        <= v2_r;
      if (en4)  v4_r        <= v3_r;
      if (en5)  v5_r        <= v4_r;
      if (en6)  v6_r        <= v5_r;
      if (en_o) out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      cmd1_r <= in_cmd;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
    end
    if (en2 && v1_r) begin
      cmd2_r <= cmd1_r;
      s_r    <= s_nxt;
    end
    if (en3 && v2_r) begin
      cmd3_r <= cmd2_r;
      pl0_r  <= pl0_nxt;
      ph0_r  <= ph0_nxt;
    end
    if (en4 && v3_r) begin
      cmd4_r <= cmd3_r;
      s0_r   <= s0_nxt;
    end
    if (en5 && v4_r) begin
      cmd5_r <= cmd4_r;
      s0b_r  <= s0_r;
      pl1_r  <= pl1_nxt;
      ph1_r  <= ph1_nxt;
    end
    if (en6 && v5_r) begin
      cmd6_r <= cmd5_r;
      s0c_r  <= s0b_r;
      s1_r   <= s1_nxt;
    end
    if (en_o && v6_r) begin
      out_cmd_r         <= cmd6_r;
      out_random_bits_r <= out_random_bits_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_bits = out_random_bits_r;

  // a stalled stage keeps its transaction
  `CHL_ASSERT_NEXT(a_stall_hold, v3_r && !en3, v3_r, "stalled stage dropped a transaction")
  `CHL_ASSERT(a_unused_zero,
              !(out_valid_r && out_cmd_r > CMD_DOUBLE) || out_random_bits_r == '0,
              "unused format code gave nonzero bits")
  `CHL_ASSERT(a_byte_width,
              !(out_valid_r && out_cmd_r == CMD_BYTE) || out_random_bits_r[63:8] == '0,
              "byte format wider than 8 bits")

endmodule
